[design/iq_mixer_fir_downconverter_core_defines.svh]
// ----------------------------------------------------------------------------
// IQ down converter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef IQ_MIXER_FIR_DOWNCONVERTER_CORE_DEFINES_SVH
`define IQ_MIXER_FIR_DOWNCONVERTER_CORE_DEFINES_SVH

// ante in one cycle implies cons in the same cycle
`define IQDDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// ante in one cycle implies cons in the next cycle
`define IQDDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/iqddc_pkg.sv]
// ----------------------------------------------------------------------------
// IQ down converter package
// Field types, tap count and the shared low-pass coefficient set.
// ----------------------------------------------------------------------------
package iqddc_pkg;

    localparam int TAPS       = 32;
    localparam int COEF_COUNT = 32;
    localparam int COEF_IW    = $clog2(COEF_COUNT);

    typedef logic signed [7:0]  t_sample;
    typedef logic signed [15:0] t_prod;
    typedef logic signed [13:0] t_coef;
    typedef logic signed [29:0] t_mult;
    typedef logic signed [31:0] t_acc;

    typedef struct packed {
        logic take;
        logic advance;
    } t_mix_ctrl;

    localparam t_coef LOWPASS_COEFS [COEF_COUNT] = '{
        -14'sd473, -14'sd417, -14'sd519, -14'sd554,
        -14'sd485, -14'sd275,  14'sd103,  14'sd660,
         14'sd1386, 14'sd2252, 14'sd3203, 14'sd4172,
         14'sd5079, 14'sd5845, 14'sd6401, 14'sd6693,
         14'sd6693, 14'sd6401, 14'sd5845, 14'sd5079,
         14'sd4172, 14'sd3203, 14'sd2252, 14'sd1386,
         14'sd660,  14'sd103, -14'sd275, -14'sd485,
        -14'sd554, -14'sd519, -14'sd417, -14'sd473
    };

    function automatic t_coef coef_at(input int k);
        if (k < COEF_COUNT) begin
            return LOWPASS_COEFS[k[COEF_IW-1:0]];
        end
        return '0;
    endfunction

endpackage

[design/iqddc_mixer.sv]
// ----------------------------------------------------------------------------
// IQ down converter mixer stage
// Multiplies the sample by both references and holds the products.
// ----------------------------------------------------------------------------
module iqddc_mixer
    import iqddc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mix_ctrl i_ctrl,
    input  t_sample   i_sample,
    input  t_sample   i_ref_inphase,
    input  t_sample   i_ref_quadrature,
    output logic      o_valid,
    output t_prod     o_prod_inphase,
    output t_prod     o_prod_quadrature
);

    logic  r_valid;
    logic  n_valid;
    t_prod r_prod_i;
    t_prod r_prod_q;
    t_prod w_prod_i;
    t_prod w_prod_q;

    assign w_prod_i = i_sample * i_ref_inphase;
    assign w_prod_q = i_sample * i_ref_quadrature;

    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.advance) begin
            n_valid = 1'b0;
        end
        if (i_ctrl.take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_prod_i <= w_prod_i;
            r_prod_q <= w_prod_q;
        end
    end

    assign o_valid           = r_valid;
    assign o_prod_inphase    = r_prod_i;
    assign o_prod_quadrature = r_prod_q;

endmodule

[design/iqddc_tap_cell.sv]
// ----------------------------------------------------------------------------
// IQ down converter tap cell
// One transposed-form tap: adds its weighted product to the neighbour's sum.
// ----------------------------------------------------------------------------
module iqddc_tap_cell
    import iqddc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  t_prod i_x,
    input  t_coef i_coef,
    input  t_acc  i_sum,
    output t_acc  o_sum
);

    t_acc  r_sum;
    t_mult w_mult;
    t_acc  n_sum;

    assign w_mult = i_x * i_coef;
    assign n_sum  = i_sum + {{2{w_mult[29]}}, w_mult};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_advance) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[design/iqddc_fir_lane.sv]
// ----------------------------------------------------------------------------
// IQ down converter filter lane
// Row of tap cells; partial sums move one cell towards the output per beat.
// ----------------------------------------------------------------------------
module iqddc_fir_lane
    import iqddc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  t_prod i_x,
    output t_acc  o_result
);

    t_acc w_sum [TAPS+1];

    assign w_sum[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        iqddc_tap_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (i_advance),
            .i_x       (i_x),
            .i_coef    (coef_at(k)),
            .i_sum     (w_sum[k+1]),
            .o_sum     (w_sum[k])
        );
    end

    assign o_result = w_sum[0];

endmodule

[design/iq_mixer_fir_downconverter_core.sv]
// ----------------------------------------------------------------------------
// IQ mixer and FIR down converter core
// Mixes a sample with I/Q references and low-pass filters each lane.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one sample and its two
// reference values per beat. Output channel: o_out_valid / i_out_ready carry
// the filtered in-phase and quadrature values, one result beat per input beat.
// An input beat passes through the mixer register and then the tap cell row,
// whose first cell is the result register. Throughput is one beat per cycle
// while the receiver is ready; each beat makes every tap cell do one multiply
// and one add, handing its partial sum to the next cell.
// Reset clears the partial sums of all cells, so the filter starts from an
// all-zero history, and drops any beat in flight. When the receiver stalls the
// result holds, the cell row stops, and o_in_ready falls once the mixer
// register holds a beat.
// ----------------------------------------------------------------------------
`include "iq_mixer_fir_downconverter_core_defines.svh"

module iq_mixer_fir_downconverter_core
    import iqddc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_sample,
    input  t_sample i_ref_inphase,
    input  t_sample i_ref_quadrature,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_acc    o_out_inphase,
    output t_acc    o_out_quadrature
);

    t_mix_ctrl w_ctrl;
    logic      w_mix_valid;
    logic      w_advance;
    t_prod     w_prod_i;
    t_prod     w_prod_q;
    logic      r_out_valid;
    logic      n_out_valid;

    assign w_advance      = w_mix_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready     = !w_mix_valid || w_advance;
    assign w_ctrl.take    = i_in_valid && o_in_ready;
    assign w_ctrl.advance = w_advance;

    iqddc_mixer u_mixer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .i_sample          (i_sample),
        .i_ref_inphase     (i_ref_inphase),
        .i_ref_quadrature  (i_ref_quadrature),
        .o_valid           (w_mix_valid),
        .o_prod_inphase    (w_prod_i),
        .o_prod_quadrature (w_prod_q)
    );

    iqddc_fir_lane u_lane_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_x       (w_prod_i),
        .o_result  (o_out_inphase)
    );

    iqddc_fir_lane u_lane_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_x       (w_prod_q),
        .o_result  (o_out_quadrature)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `IQDDC_ASSERT_NEXT(a_take_fills_mixer, w_ctrl.take, w_mix_valid, "accepted beat lost before mixer")
    `IQDDC_ASSERT_NEXT(a_advance_gives_result, w_advance, r_out_valid, "advanced beat not presented")
    `IQDDC_ASSERT_NEXT(a_mixer_holds, w_mix_valid && !w_advance, w_mix_valid && $stable(w_prod_i) && $stable(w_prod_q), "mixer beat dropped or altered")
    `IQDDC_ASSERT_SAME(a_no_overrun, w_advance, !r_out_valid || i_out_ready, "result overwritten while stalled")

endmodule
